@@ hdl/rmq_pkg.sv @@
// Shared types and constants for the rotation matrix to quaternion pipeline.
// Used by rmq_sqrt_cell, rmq_div_cell and rotation_matrix_to_quaternion.
`default_nettype none
package rmq_pkg;
   localparam int NumLanes  = 4;
   localparam int SqrtCells = 24;
   localparam int DivCells  = 16;

   localparam logic [1:0] LANE_W = 2'd0;
   localparam logic [1:0] LANE_X = 2'd1;
   localparam logic [1:0] LANE_Y = 2'd2;
   localparam logic [1:0] LANE_Z = 2'd3;

   localparam logic [16:0] ONE_Q14  = 17'd16384;
   localparam logic [47:0] BIT_INIT = 48'h4000_0000_0000;

   // data that rides along the pipe untouched
   typedef struct packed {
      logic                   ok;
      logic [1:0]             qsel;
      logic [3:0]             neg;
      logic [3:0][16:0]       mag;
   } side_type;

   typedef struct packed {
      logic       valid;
      side_type   side;
      logic [47:0] v;
      logic [47:0] res;
      logic [47:0] bmask;
   } sqrt_type;

   typedef struct packed {
      logic             valid;
      side_type         side;
      logic [23:0]      root;
      logic [3:0][40:0] rem;
      logic [40:0]      dsh;
      logic [3:0][15:0] quo;
   } div_type;
endpackage
`default_nettype wire

@@ hdl/rmq_sqrt_cell.sv @@
// One bit of the integer square root: a registered digit step.
// Depends on rmq_pkg.
`default_nettype none
module rmq_sqrt_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire rmq_pkg::sqrt_type d_in,
   output rmq_pkg::sqrt_type      d_out
);
   rmq_pkg::sqrt_type q_ff, q_in;
   logic [47:0] trial;

   always_comb begin
      trial = d_in.res + d_in.bmask;
      q_in = d_in;
      if (d_in.v >= trial) begin
         q_in.v   = d_in.v - trial;
         q_in.res = (d_in.res >> 1) + d_in.bmask;
      end else begin
         q_in.res = d_in.res >> 1;
      end
      q_in.bmask = d_in.bmask >> 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else if (en) begin
         q_ff.valid <= q_in.valid;
      end
      if (en) begin
         q_ff.side  <= q_in.side;
         q_ff.v     <= q_in.v;
         q_ff.res   <= q_in.res;
         q_ff.bmask <= q_in.bmask;
      end
   end

   assign d_out = q_ff;
endmodule
`default_nettype wire

@@ hdl/rmq_div_cell.sv @@
// One quotient bit of restoring division for all four lanes, registered.
// Depends on rmq_pkg.
`default_nettype none
module rmq_div_cell (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire rmq_pkg::div_type d_in,
   output rmq_pkg::div_type      d_out
);
   rmq_pkg::div_type q_ff, q_in;

   always_comb begin
      q_in = d_in;
      for (int i = 0; i < rmq_pkg::NumLanes; i++) begin
         if (d_in.rem[i] >= d_in.dsh) begin
            q_in.rem[i] = d_in.rem[i] - d_in.dsh;
            q_in.quo[i] = {d_in.quo[i][14:0], 1'b1};
         end else begin
            q_in.quo[i] = {d_in.quo[i][14:0], 1'b0};
         end
      end
      q_in.dsh = d_in.dsh >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else if (en) begin
         q_ff.valid <= q_in.valid;
      end
      if (en) begin
         q_ff.side <= q_in.side;
         q_ff.root <= q_in.root;
         q_ff.rem  <= q_in.rem;
         q_ff.dsh  <= q_in.dsh;
         q_ff.quo  <= q_in.quo;
      end
   end

   assign d_out = q_ff;
endmodule
`default_nettype wire

@@ hdl/rotation_matrix_to_quaternion.sv @@
// Top level: Shepperd rotation matrix to quaternion, Q1.14 in and out.
// Depends on rmq_pkg, rmq_sqrt_cell and rmq_div_cell.
`default_nettype none
// One matrix beat is taken every cycle while rsp_stall is low; the result
// passes through 24 square-root cells, 16 divider cells and the output
// register. The whole pipe freezes while a result waits under rsp_stall,
// and req_stall follows that condition.
module rotation_matrix_to_quaternion (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_m00,
   input  wire logic signed [15:0] req_m01,
   input  wire logic signed [15:0] req_m02,
   input  wire logic signed [15:0] req_m10,
   input  wire logic signed [15:0] req_m11,
   input  wire logic signed [15:0] req_m12,
   input  wire logic signed [15:0] req_m20,
   input  wire logic signed [15:0] req_m21,
   input  wire logic signed [15:0] req_m22,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_quat_w,
   output logic signed [15:0]      rsp_quat_x,
   output logic signed [15:0]      rsp_quat_y,
   output logic signed [15:0]      rsp_quat_z
);
   logic adv;
   rmq_pkg::sqrt_type sq [0:rmq_pkg::SqrtCells];
   rmq_pkg::div_type  dv [0:rmq_pkg::DivCells];

   logic signed [18:0] t, rad;
   logic signed [16:0] s01p, s20p, s12p, d12m, d20m, d01m;
   logic signed [3:0][16:0] num;

   logic               rsp_valid_ff;
   logic [3:0][15:0]   quat_ff, quat_in;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   function automatic logic signed [18:0] ext(input logic signed [15:0] a);
      return {{3{a[15]}}, a};
   endfunction

   always_comb begin
      s01p = {req_m01[15], req_m01} + {req_m10[15], req_m10};
      s20p = {req_m20[15], req_m20} + {req_m02[15], req_m02};
      s12p = {req_m12[15], req_m12} + {req_m21[15], req_m21};
      d12m = {req_m12[15], req_m12} - {req_m21[15], req_m21};
      d20m = {req_m20[15], req_m20} - {req_m02[15], req_m02};
      d01m = {req_m01[15], req_m01} - {req_m10[15], req_m10};
      t = {2'b00, rmq_pkg::ONE_Q14} + ext(req_m00) + ext(req_m11) + ext(req_m22);
      sq[0] = '0;
      num = '0;
      if (t > 0) begin
         rad = t;
         sq[0].side.qsel = rmq_pkg::LANE_W;
         num[rmq_pkg::LANE_X] = d12m;
         num[rmq_pkg::LANE_Y] = d20m;
         num[rmq_pkg::LANE_Z] = d01m;
      end else if (req_m00 > req_m11 && req_m00 > req_m22) begin
         rad = {2'b00, rmq_pkg::ONE_Q14} + ext(req_m00) - ext(req_m11) - ext(req_m22);
         sq[0].side.qsel = rmq_pkg::LANE_X;
         num[rmq_pkg::LANE_Y] = s01p;
         num[rmq_pkg::LANE_Z] = s20p;
         num[rmq_pkg::LANE_W] = d12m;
      end else if (req_m11 > req_m22) begin
         rad = {2'b00, rmq_pkg::ONE_Q14} + ext(req_m11) - ext(req_m00) - ext(req_m22);
         sq[0].side.qsel = rmq_pkg::LANE_Y;
         num[rmq_pkg::LANE_X] = s01p;
         num[rmq_pkg::LANE_Z] = s12p;
         num[rmq_pkg::LANE_W] = d20m;
      end else begin
         rad = {2'b00, rmq_pkg::ONE_Q14} + ext(req_m22) - ext(req_m00) - ext(req_m11);
         sq[0].side.qsel = rmq_pkg::LANE_Z;
         num[rmq_pkg::LANE_X] = s20p;
         num[rmq_pkg::LANE_Y] = s12p;
         num[rmq_pkg::LANE_W] = d01m;
      end
      sq[0].valid   = req_valid;
      sq[0].side.ok = rad > 0;
      for (int i = 0; i < rmq_pkg::NumLanes; i++) begin
         sq[0].side.neg[i] = num[i][16];
         sq[0].side.mag[i] = num[i][16] ? 17'(-num[i]) : 17'(num[i]);
      end
      // radicand scaled by 2^30; a non-positive one is never used
      sq[0].v     = sq[0].side.ok ? {1'b0, rad[16:0], 30'd0} : 48'd0;
      sq[0].res   = '0;
      sq[0].bmask = rmq_pkg::BIT_INIT;
   end

   for (genvar k = 0; k < rmq_pkg::SqrtCells; k++) begin : g_sqrt
      rmq_sqrt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (adv),
         .d_in  (sq[k]),
         .d_out (sq[k+1])
      );
   end

   // dividend 2*n*2^21 + R over divisor 2*R; first cell tests quotient bit 15
   always_comb begin
      dv[0].valid = sq[rmq_pkg::SqrtCells].valid;
      dv[0].side  = sq[rmq_pkg::SqrtCells].side;
      dv[0].root  = sq[rmq_pkg::SqrtCells].res[23:0];
      for (int i = 0; i < rmq_pkg::NumLanes; i++) begin
         dv[0].rem[i] = {2'b00, dv[0].side.mag[i], 22'd0} + {17'd0, dv[0].root};
      end
      dv[0].dsh = {1'b0, dv[0].root, 16'd0};
      dv[0].quo = '0;
   end

   for (genvar k = 0; k < rmq_pkg::DivCells; k++) begin : g_div
      rmq_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (adv),
         .d_in  (dv[k]),
         .d_out (dv[k+1])
      );
   end

   always_comb begin
      logic [24:0] qsum;
      logic [15:0] mg;
      logic [14:0] sat;
      logic        sg;
      qsum = {1'b0, dv[rmq_pkg::DivCells].root} + 25'd256;
      for (int i = 0; i < rmq_pkg::NumLanes; i++) begin
         if (2'(i) == dv[rmq_pkg::DivCells].side.qsel) begin
            mg = qsum[24:9];
            sg = 1'b0;
         end else begin
            mg = dv[rmq_pkg::DivCells].quo[i][15] ? 16'h7fff : dv[rmq_pkg::DivCells].quo[i];
            sg = dv[rmq_pkg::DivCells].side.neg[i];
         end
         sat = (mg > 16'd16384) ? 15'd16384 : mg[14:0];
         // vector parts leave conjugated
         if (2'(i) != rmq_pkg::LANE_W) begin
            sg = !sg;
         end
         if (!dv[rmq_pkg::DivCells].side.ok) begin
            quat_in[i] = '0;
         end else begin
            quat_in[i] = sg ? 16'(-{1'b0, sat}) : {1'b0, sat};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv[rmq_pkg::DivCells].valid;
      end
      if (adv) begin
         quat_ff <= quat_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_quat_w = quat_ff[rmq_pkg::LANE_W];
   assign rsp_quat_x = quat_ff[rmq_pkg::LANE_X];
   assign rsp_quat_y = quat_ff[rmq_pkg::LANE_Y];
   assign rsp_quat_z = quat_ff[rmq_pkg::LANE_Z];

   a_w_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_quat_w <= 16'sd16384 && rsp_quat_w >= -16'sd16384))
      else $error("quat_w out of range");
   a_xyz_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_quat_x <= 16'sd16384 && rsp_quat_x >= -16'sd16384 &&
                     rsp_quat_y <= 16'sd16384 && rsp_quat_y >= -16'sd16384 &&
                     rsp_quat_z <= 16'sd16384 && rsp_quat_z >= -16'sd16384))
      else $error("vector part out of range");
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(sq[1].v) && $stable(dv[1].rem))
      else $error("pipe moved while frozen");
endmodule
`default_nettype wire

@@ bench/rotation_matrix_to_quaternion_test.sv @@
// Testbench for rotation_matrix_to_quaternion: directed matrices, then random ones,
// each result checked against a behavioral Shepperd predictor. Needs only the RTL.
module rotation_matrix_to_quaternion_test;

   typedef struct {
      logic signed [15:0] m [9];
   } matrix_type;

   typedef struct {
      logic signed [15:0] w, x, y, z;
   } quat_type;

   typedef struct {
      logic signed [15:0] m [9];
      bit                 known;
      logic signed [15:0] w, x, y, z;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [15:0] req_m [9];
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [15:0] rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;

   quat_type pending_quats [$];
   int errors = 0;
   int cycles = 0;
   bit quiet = 0;   // no idling near the end
   localparam int CycleLimit = 200000;

   initial for (int i = 0; i < 9; i++) req_m[i] = '0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   rotation_matrix_to_quaternion i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_m00(req_m[0]), .req_m01(req_m[1]), .req_m02(req_m[2]),
      .req_m10(req_m[3]), .req_m11(req_m[4]), .req_m12(req_m[5]),
      .req_m20(req_m[6]), .req_m21(req_m[7]), .req_m22(req_m[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_quat_w(rsp_quat_w), .rsp_quat_x(rsp_quat_x),
      .rsp_quat_y(rsp_quat_y), .rsp_quat_z(rsp_quat_z)
   );

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // round(n * 2^21 / root), ties away from zero
   function automatic longint div_root(longint n, longint unsigned root);
      longint unsigned mag, q;
      mag = (n < 0) ? -n : n;
      q = ((mag << 22) + root) / (root * 2);
      return (n < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [15:0] clamp_q14(longint v);
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      return v[15:0];
   endfunction

   function automatic quat_type matrix_to_quat(logic signed [15:0] m [9]);
      longint a00, a01, a02, a10, a11, a12, a20, a21, a22, rad, w, x, y, z, qtr;
      longint unsigned root;
      int col;
      quat_type q;
      a00 = m[0]; a01 = m[1]; a02 = m[2];
      a10 = m[3]; a11 = m[4]; a12 = m[5];
      a20 = m[6]; a21 = m[7]; a22 = m[8];
      w = 0; x = 0; y = 0; z = 0;
      rad = 16384 + a00 + a11 + a22;
      col = 3;
      if (rad <= 0) begin
         if (a00 > a11 && a00 > a22) begin
            rad = 16384 + a00 - a11 - a22; col = 0;
         end else if (a11 > a22) begin
            rad = 16384 + a11 - a00 - a22; col = 1;
         end else begin
            rad = 16384 + a22 - a00 - a11; col = 2;
         end
      end
      if (rad > 0) begin
         root = int_sqrt(longint'(rad) << 30);
         qtr = (root + 256) >> 9;
         case (col)
            0: begin
               x = qtr; y = div_root(a01 + a10, root);
               z = div_root(a20 + a02, root); w = div_root(a12 - a21, root);
            end
            1: begin
               x = div_root(a01 + a10, root); y = qtr;
               z = div_root(a12 + a21, root); w = div_root(a20 - a02, root);
            end
            2: begin
               x = div_root(a20 + a02, root); y = div_root(a12 + a21, root);
               z = qtr; w = div_root(a01 - a10, root);
            end
            default: begin
               x = div_root(a12 - a21, root); y = div_root(a20 - a02, root);
               z = div_root(a01 - a10, root); w = qtr;
            end
         endcase
      end
      q.w = clamp_q14(w);
      q.x = clamp_q14(-x);
      q.y = clamp_q14(-y);
      q.z = clamp_q14(-z);
      return q;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // result side: random stall bursts, check every accepted beat
   initial begin
      int burst;
      quat_type q;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            if (pending_quats.size() == 0) begin
               report_mismatch("unexpected beat", 0, 0);
            end else begin
               q = pending_quats.pop_front();
               if (rsp_quat_w !== q.w) report_mismatch("quat_w", rsp_quat_w, q.w);
               if (rsp_quat_x !== q.x) report_mismatch("quat_x", rsp_quat_x, q.x);
               if (rsp_quat_y !== q.y) report_mismatch("quat_y", rsp_quat_y, q.y);
               if (rsp_quat_z !== q.z) report_mismatch("quat_z", rsp_quat_z, q.z);
            end
         end
         if (burst > 0) begin
            burst--;
            if (burst == 0) rsp_stall <= 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 5);
            rsp_stall <= 1;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout");
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_matrix(logic signed [15:0] m [9], bit known, quat_type want);
      quat_type q;
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         gap = $urandom_range(1, 5);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      for (int i = 0; i < 9; i++) req_m[i] <= m[i];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      q = matrix_to_quat(m);
      if (known && (q.w !== want.w || q.x !== want.x || q.y !== want.y || q.z !== want.z))
         report_mismatch("predictor vs table", q.w, want.w);
      pending_quats.insert(pending_quats.size(), q);
   endtask

   function automatic logic signed [15:0] rand_entry(int mode);
      case (mode)
         0: return 16'($urandom_range(0, 32768) - 16384);
         1: return 16'($urandom);   // any pattern, saturating
         default: return 16'($urandom_range(0, 200) - 100);
      endcase
   endfunction

   initial begin
      row_type rows [$];
      row_type r;
      quat_type want;
      logic signed [15:0] m [9];
      int mode, perm;
      repeat (5) @(posedge clock);
      reset <= 0;

      // identity -> w = 1, vector zero
      r.m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; r.known = 1;
      r.w = 16384; r.x = 0; r.y = 0; r.z = 0; rows.insert(rows.size(), r);
      // 180 degrees about x, y, z: column branches
      r.m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
      r.w = 0; r.x = -16384; r.y = 0; r.z = 0; rows.insert(rows.size(), r);
      r.m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};
      r.w = 0; r.x = 0; r.y = -16384; r.z = 0; rows.insert(rows.size(), r);
      r.m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};
      r.w = 0; r.x = 0; r.y = 0; r.z = -16384; rows.insert(rows.size(), r);
      r.known = 0;
      // equal negative diagonals fall through to column 2
      r.m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; rows.insert(rows.size(), r);
      r.m = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}; rows.insert(rows.size(), r);
      r.m = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; rows.insert(rows.size(), r);
      r.m = '{0, 11585, 0, -11585, 0, 0, 0, 0, 16384}; rows.insert(rows.size(), r);
      r.m = '{32767, 32767, -32768, -32768, 32767, 32767, 32767, -32768, 32767};
      rows.insert(rows.size(), r);
      r.m = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
      rows.insert(rows.size(), r);
      r.m = '{-16384, 16384, 16384, 16384, -16384, 16384, 16384, 16384, -16384};
      rows.insert(rows.size(), r);
      // ties between diagonals fall to later columns
      r.m = '{-8192, 100, -100, 300, -8192, 50, -50, 7, -8192}; rows.insert(rows.size(), r);
      r.m = '{0, 1, 2, 3, -16384, 4, 5, 6, -16384}; rows.insert(rows.size(), r);
      r.m = '{-16384, -1, 5, 9, 0, -7, 3, 2, -16384}; rows.insert(rows.size(), r);
      r.m = '{-16384, 100, 200, -300, -16384, 400, 500, -600, 0};
      rows.insert(rows.size(), r);
      r.m = '{-1, -1, -1, -1, -1, -1, -1, -1, -16383}; rows.insert(rows.size(), r);

      foreach (rows[i]) begin
         want.w = rows[i].w; want.x = rows[i].x; want.y = rows[i].y; want.z = rows[i].z;
         send_matrix(rows[i].m, rows[i].known, want);
      end

      for (int n = 0; n < 650; n++) begin
         if (n > 560) quiet = 1;
         mode = $urandom_range(0, 9);
         for (int i = 0; i < 9; i++)
            m[i] = rand_entry(mode < 6 ? 0 : (mode < 8 ? 1 : 2));
         // push some toward the non-trace branches
         if (mode == 2 || mode == 3) begin
            perm = $urandom_range(0, 2);
            for (int d = 0; d < 3; d++)
               m[d * 4] = (d == perm) ? 16'($urandom_range(0, 16384))
                                      : 16'(-$urandom_range(8192, 16384));
         end
         send_matrix(m, 0, want);
      end
      req_valid <= 0;
      quiet = 1;
      while (pending_quats.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
